// ----- hw/rtl/rgb_hue_color_classifier_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RGB hue color classifier.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef RGB_HUE_COLOR_CLASSIFIER_UNIT_ASSERT_SVH
`define RGB_HUE_COLOR_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RHCC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RHCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rhcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhcc_pkg
// Types, class codes, register indexes and the hue binning function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhcc_pkg;

    localparam int CH_W     = 8;
    localparam int NUM_W    = 14;   // |diff| * 60 fits in 14 bits
    localparam int Q_W      = 6;    // quotient never exceeds 60
    localparam int HUE_W    = 9;
    localparam int CLS_W    = 5;
    localparam int CFG_IDX_W = 3;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [CLS_W-1:0] color_class;
        logic [HUE_W-1:0] hue_degrees;
    } t_result;

    // Which channel is the maximum; fixes the hue sector base.
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_SPREAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_GRAY_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_LIMIT      = 3'd4;

    localparam logic [CH_W-1:0] RST_BLACK_LEVEL     = 8'd24;
    localparam logic [CH_W-1:0] RST_GRAY_SPREAD     = 8'd24;
    localparam logic [CH_W-1:0] RST_DARK_GRAY_LIMIT = 8'd90;
    localparam logic [CH_W-1:0] RST_WHITE_LIMIT     = 8'd200;
    localparam logic [CH_W-1:0] RST_DARK_LIMIT      = 8'd110;

    localparam logic [CLS_W-1:0] CLS_BLACK      = 5'd0;
    localparam logic [CLS_W-1:0] CLS_DARK_GRAY  = 5'd1;
    localparam logic [CLS_W-1:0] CLS_GRAY       = 5'd2;
    localparam logic [CLS_W-1:0] CLS_WHITE      = 5'd3;
    localparam logic [CLS_W-1:0] CLS_BROWN      = 5'd4;
    localparam logic [CLS_W-1:0] CLS_RED        = 5'd5;
    localparam logic [CLS_W-1:0] CLS_ORANGE     = 5'd6;
    localparam logic [CLS_W-1:0] CLS_OLIVE      = 5'd7;
    localparam logic [CLS_W-1:0] CLS_YELLOW     = 5'd8;
    localparam logic [CLS_W-1:0] CLS_LIME       = 5'd9;
    localparam logic [CLS_W-1:0] CLS_DARK_GREEN = 5'd10;
    localparam logic [CLS_W-1:0] CLS_GREEN      = 5'd11;
    localparam logic [CLS_W-1:0] CLS_TEAL       = 5'd12;
    localparam logic [CLS_W-1:0] CLS_CYAN       = 5'd13;
    localparam logic [CLS_W-1:0] CLS_SKY_BLUE   = 5'd14;
    localparam logic [CLS_W-1:0] CLS_NAVY       = 5'd15;
    localparam logic [CLS_W-1:0] CLS_BLUE       = 5'd16;
    localparam logic [CLS_W-1:0] CLS_PURPLE     = 5'd17;
    localparam logic [CLS_W-1:0] CLS_VIOLET     = 5'd18;
    localparam logic [CLS_W-1:0] CLS_MAGENTA    = 5'd19;
    localparam logic [CLS_W-1:0] CLS_PINK       = 5'd20;

    localparam logic [HUE_W-1:0] HUE_SEC_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_SEC_BLUE  = 9'd240;
    localparam logic [HUE_W-1:0] HUE_FULL      = 9'd360;

    localparam logic [HUE_W-1:0] BIN_RED     = 9'd15;
    localparam logic [HUE_W-1:0] BIN_ORANGE  = 9'd35;
    localparam logic [HUE_W-1:0] BIN_YELLOW  = 9'd55;
    localparam logic [HUE_W-1:0] BIN_LIME    = 9'd80;
    localparam logic [HUE_W-1:0] BIN_GREEN   = 9'd150;
    localparam logic [HUE_W-1:0] BIN_CYAN    = 9'd180;
    localparam logic [HUE_W-1:0] BIN_SKY     = 9'd220;
    localparam logic [HUE_W-1:0] BIN_BLUE    = 9'd260;
    localparam logic [HUE_W-1:0] BIN_VIOLET  = 9'd290;
    localparam logic [HUE_W-1:0] BIN_PINK    = 9'd330;

    function automatic logic [CLS_W-1:0] bin_hue(input logic [HUE_W-1:0] hue,
                                                 input logic dark);
        logic [CLS_W-1:0] cls;
        if (hue < BIN_RED)         cls = dark ? CLS_BROWN      : CLS_RED;
        else if (hue < BIN_ORANGE) cls = dark ? CLS_BROWN      : CLS_ORANGE;
        else if (hue < BIN_YELLOW) cls = dark ? CLS_OLIVE      : CLS_YELLOW;
        else if (hue < BIN_LIME)   cls = dark ? CLS_OLIVE      : CLS_LIME;
        else if (hue < BIN_GREEN)  cls = dark ? CLS_DARK_GREEN : CLS_GREEN;
        else if (hue < BIN_CYAN)   cls = dark ? CLS_TEAL       : CLS_CYAN;
        else if (hue < BIN_SKY)    cls = dark ? CLS_TEAL       : CLS_SKY_BLUE;
        else if (hue < BIN_BLUE)   cls = dark ? CLS_NAVY       : CLS_BLUE;
        else if (hue < BIN_VIOLET) cls = dark ? CLS_PURPLE     : CLS_VIOLET;
        else if (hue < BIN_PINK)   cls = dark ? CLS_MAGENTA    : CLS_PINK;
        else                       cls = dark ? CLS_BROWN      : CLS_RED;
        return cls;
    endfunction

endpackage

// ----- hw/rtl/rhcc_div_step.sv -----
// ----------------------------------------------------------------------------
// rhcc_div_step
// Three restoring-division steps: produces quotient bits LSB+2 down to LSB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhcc_div_step #(
    parameter int LSB = 0
) (
    input  logic [rhcc_pkg::NUM_W-1:0] i_rem,
    input  logic [rhcc_pkg::CH_W-1:0]  i_spread,
    input  logic [rhcc_pkg::Q_W-1:0]   i_quo,
    output logic [rhcc_pkg::NUM_W-1:0] o_rem,
    output logic [rhcc_pkg::Q_W-1:0]   o_quo
);

    always_comb begin
        logic [rhcc_pkg::NUM_W-1:0] rem;
        logic [rhcc_pkg::NUM_W-1:0] trial;
        rem   = i_rem;
        o_quo = i_quo;
        for (int k = LSB + 2; k >= LSB; k--) begin
            trial = rhcc_pkg::NUM_W'(i_spread) << k;
            if (rem >= trial) begin
                rem      = rem - trial;
                o_quo[k] = 1'b1;
            end
        end
        o_rem = rem;
    end

endmodule

// ----- hw/rtl/rgb_hue_color_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// rgb_hue_color_classifier_unit: RGB888 pixel to hue and color name.
// A request passes through registered stages A to E before its result is valid.
// Throughput is one request per cycle; a stall freezes all five stages.
// Synchronous reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_hue_color_classifier_unit_assert.svh"

module rgb_hue_color_classifier_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_pix_valid,
    output logic                             o_pix_ready,
    input  rhcc_pkg::t_pixel                 i_pix,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output rhcc_pkg::t_result                o_res,
    input  logic                             i_cfg_we,
    input  logic [rhcc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rhcc_pkg::CH_W-1:0]        i_cfg_data
);

    localparam int CH_W  = rhcc_pkg::CH_W;
    localparam int NUM_W = rhcc_pkg::NUM_W;
    localparam int Q_W   = rhcc_pkg::Q_W;
    localparam int HUE_W = rhcc_pkg::HUE_W;
    localparam int CLS_W = rhcc_pkg::CLS_W;

    // Configuration registers.
    logic [CH_W-1:0] r_black_level, r_gray_spread, r_dark_gray_limit;
    logic [CH_W-1:0] r_white_limit, r_dark_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_level     <= rhcc_pkg::RST_BLACK_LEVEL;
            r_gray_spread     <= rhcc_pkg::RST_GRAY_SPREAD;
            r_dark_gray_limit <= rhcc_pkg::RST_DARK_GRAY_LIMIT;
            r_white_limit     <= rhcc_pkg::RST_WHITE_LIMIT;
            r_dark_limit      <= rhcc_pkg::RST_DARK_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rhcc_pkg::REG_BLACK_LEVEL:     r_black_level     <= i_cfg_data;
                rhcc_pkg::REG_GRAY_SPREAD:     r_gray_spread     <= i_cfg_data;
                rhcc_pkg::REG_DARK_GRAY_LIMIT: r_dark_gray_limit <= i_cfg_data;
                rhcc_pkg::REG_WHITE_LIMIT:     r_white_limit     <= i_cfg_data;
                rhcc_pkg::REG_DARK_LIMIT:      r_dark_limit      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together whenever the output slot is free.
    logic w_en;
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid;

    assign w_en        = !r_e_valid || i_res_ready;
    assign o_pix_ready = w_en;
    assign o_res_valid = r_e_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_pix_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    // Stage A: extremes, spread, achromatic decision and sector selection.
    logic [CH_W-1:0]       n_a_spread, n_a_absd;
    logic [CLS_W-1:0]      n_a_cls;
    logic                  n_a_chrom, n_a_neg, n_a_dark;
    rhcc_pkg::t_sector     n_a_sec;

    always_comb begin
        logic [CH_W-1:0] mx, mn, op_a, op_b;
        logic            black, achrom;
        mx = i_pix.red;
        mn = i_pix.red;
        if (i_pix.green > mx) mx = i_pix.green;
        if (i_pix.blue  > mx) mx = i_pix.blue;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue  < mn) mn = i_pix.blue;
        n_a_spread = mx - mn;
        black  = mx < r_black_level;
        achrom = (n_a_spread == '0) || (n_a_spread < r_gray_spread);

        if (black)                      n_a_cls = rhcc_pkg::CLS_BLACK;
        else if (mx < r_dark_gray_limit) n_a_cls = rhcc_pkg::CLS_DARK_GRAY;
        else if (mx < r_white_limit)    n_a_cls = rhcc_pkg::CLS_GRAY;
        else                            n_a_cls = rhcc_pkg::CLS_WHITE;
        n_a_chrom = !black && !achrom;
        n_a_dark  = mx < r_dark_limit;

        // Red wins ties over green, green over blue.
        if (mx == i_pix.red) begin
            n_a_sec = rhcc_pkg::SEC_RED;
            op_a    = i_pix.green;
            op_b    = i_pix.blue;
        end else if (mx == i_pix.green) begin
            n_a_sec = rhcc_pkg::SEC_GREEN;
            op_a    = i_pix.blue;
            op_b    = i_pix.red;
        end else begin
            n_a_sec = rhcc_pkg::SEC_BLUE;
            op_a    = i_pix.red;
            op_b    = i_pix.green;
        end
        n_a_neg  = op_a < op_b;
        n_a_absd = n_a_neg ? (op_b - op_a) : (op_a - op_b);
    end

    logic [CH_W-1:0]   r_a_spread, r_a_absd;
    logic [CLS_W-1:0]  r_a_cls;
    logic              r_a_chrom, r_a_neg, r_a_dark;
    rhcc_pkg::t_sector r_a_sec;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_spread <= n_a_spread;
            r_a_absd   <= n_a_absd;
            r_a_cls    <= n_a_cls;
            r_a_chrom  <= n_a_chrom;
            r_a_neg    <= n_a_neg;
            r_a_dark   <= n_a_dark;
            r_a_sec    <= n_a_sec;
        end
    end

    // Stage B: numerator |diff| * 60 as (x << 6) - (x << 2).
    logic [NUM_W-1:0] n_b_num;
    assign n_b_num = (NUM_W'(r_a_absd) << 6) - (NUM_W'(r_a_absd) << 2);

    logic [NUM_W-1:0]  r_b_num;
    logic [CH_W-1:0]   r_b_spread;
    logic [CLS_W-1:0]  r_b_cls;
    logic              r_b_chrom, r_b_neg, r_b_dark;
    rhcc_pkg::t_sector r_b_sec;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_num    <= n_b_num;
            r_b_spread <= r_a_spread;
            r_b_cls    <= r_a_cls;
            r_b_chrom  <= r_a_chrom;
            r_b_neg    <= r_a_neg;
            r_b_dark   <= r_a_dark;
            r_b_sec    <= r_a_sec;
        end
    end

    // Stage C: upper three quotient bits.
    logic [NUM_W-1:0] n_c_rem;
    logic [Q_W-1:0]   n_c_quo;

    rhcc_div_step #(.LSB(3)) u_div_hi (
        .i_rem    (r_b_num),
        .i_spread (r_b_spread),
        .i_quo    ('0),
        .o_rem    (n_c_rem),
        .o_quo    (n_c_quo)
    );

    logic [NUM_W-1:0]  r_c_rem;
    logic [Q_W-1:0]    r_c_quo;
    logic [CH_W-1:0]   r_c_spread;
    logic [CLS_W-1:0]  r_c_cls;
    logic              r_c_chrom, r_c_neg, r_c_dark;
    rhcc_pkg::t_sector r_c_sec;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_rem    <= n_c_rem;
            r_c_quo    <= n_c_quo;
            r_c_spread <= r_b_spread;
            r_c_cls    <= r_b_cls;
            r_c_chrom  <= r_b_chrom;
            r_c_neg    <= r_b_neg;
            r_c_dark   <= r_b_dark;
            r_c_sec    <= r_b_sec;
        end
    end

    // Stage D: lower three quotient bits; the remainder is not needed after.
    logic [NUM_W-1:0] n_d_rem;
    logic [Q_W-1:0]   n_d_quo;

    rhcc_div_step #(.LSB(0)) u_div_lo (
        .i_rem    (r_c_rem),
        .i_spread (r_c_spread),
        .i_quo    (r_c_quo),
        .o_rem    (n_d_rem),
        .o_quo    (n_d_quo)
    );

    logic [Q_W-1:0]    r_d_quo;
    logic [CLS_W-1:0]  r_d_cls;
    logic              r_d_chrom, r_d_neg, r_d_dark;
    rhcc_pkg::t_sector r_d_sec;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_quo    <= n_d_quo;
            r_d_cls    <= r_c_cls;
            r_d_chrom  <= r_c_chrom;
            r_d_neg    <= r_c_neg;
            r_d_dark   <= r_c_dark;
            r_d_sec    <= r_c_sec;
        end
    end

    // Stage E: apply sign and sector base, wrap below zero, bin the hue.
    rhcc_pkg::t_result n_e_res;

    always_comb begin
        logic [HUE_W-1:0] base, quo, hue;
        quo = HUE_W'(r_d_quo);
        case (r_d_sec)
            rhcc_pkg::SEC_GREEN: base = rhcc_pkg::HUE_SEC_GREEN;
            rhcc_pkg::SEC_BLUE:  base = rhcc_pkg::HUE_SEC_BLUE;
            default:             base = '0;
        endcase
        // A negative part in the red sector wraps; a zero quotient stays at zero.
        if (!r_d_neg)
            hue = base + quo;
        else if (r_d_sec == rhcc_pkg::SEC_RED && quo != '0)
            hue = rhcc_pkg::HUE_FULL - quo;
        else
            hue = base - quo;

        if (r_d_chrom) begin
            n_e_res.color_class = rhcc_pkg::bin_hue(hue, r_d_dark);
            n_e_res.hue_degrees = hue;
        end else begin
            n_e_res.color_class = r_d_cls;
            n_e_res.hue_degrees = '0;
        end
    end

    rhcc_pkg::t_result r_e_res;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_res <= n_e_res;
        end
    end

    assign o_res = r_e_res;

    // The remainder of a quotient digit pass is always below the divisor.
    logic w_d_rem_ok;
    assign w_d_rem_ok = n_d_rem < NUM_W'(r_c_spread) || !r_c_chrom || !r_c_valid;

    `RHCC_ASSERT_IMPLY(a_achrom_hue_zero, i_clk, i_rst_n,
        o_res_valid && o_res.color_class <= rhcc_pkg::CLS_WHITE,
        o_res.hue_degrees == '0, "achromatic result carries a nonzero hue")
    `RHCC_ASSERT_NEXT(a_stage_advance, i_clk, i_rst_n,
        r_a_valid && w_en, r_b_valid, "request lost between stages A and B")
    `RHCC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        r_d_valid && !w_en, r_d_valid && $stable(r_d_quo),
        "stage D changed during a stall")
    `RHCC_ASSERT_IMPLY(a_div_rem, i_clk, i_rst_n,
        r_c_valid && r_c_chrom, w_d_rem_ok, "divider remainder not below spread")

endmodule

// ----- dv/rgb_hue_color_classifier_unit_tb.sv -----
// ----------------------------------------------------------------------------
// rgb_hue_color_classifier_unit_tb
// Self-checking bench for the pixel color classifier. A table of directed
// pixels runs first, then random pixels under several register settings.
// Results are checked against the table or a hue and color-name predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hue_color_classifier_unit_tb;

    localparam int CH_W            = rhcc_pkg::CH_W;
    localparam int CLS_W           = rhcc_pkg::CLS_W;
    localparam int HUE_W           = rhcc_pkg::HUE_W;
    localparam int CFG_IDX_W       = rhcc_pkg::CFG_IDX_W;
    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 12;
    localparam int REG_COUNT       = 5;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES   = 10;
    localparam int RUN_LIMIT_NS    = 5_000_000;

    typedef struct {
        rhcc_pkg::t_pixel  px;
        bit                known;
        rhcc_pkg::t_result want;
    } t_probe;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_pix_valid = 1'b0;
    logic                 o_pix_ready;
    rhcc_pkg::t_pixel     i_pix = '0;
    logic                 o_res_valid;
    logic                 i_res_ready = 1'b0;
    rhcc_pkg::t_result    o_res;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CH_W-1:0]      i_cfg_data = '0;

    // Local copy of the configuration registers, indexed by register code.
    logic [CH_W-1:0]   cfg_model [REG_COUNT];
    rhcc_pkg::t_result pending_results [$];
    t_probe            probe_table [$];
    int                error_count = 0;
    int                results_checked = 0;
    int                pixels_sent = 0;
    int                burst_left = 0;
    bit                no_idle = 1'b0;
    logic [31:0]       classes_seen = '0;

    // Receiver stall pattern state.
    int              rx_mode = 0;
    int              rx_left = 0;

    rgb_hue_color_classifier_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pix       (i_pix),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [CLS_W-1:0] hue_to_class(input int hue, input bit dark);
        int               edges [10];
        logic [CLS_W-1:0] dark_names [11];
        logic [CLS_W-1:0] light_names [11];
        int               bin;
        edges       = '{15, 35, 55, 80, 150, 180, 220, 260, 290, 330};
        dark_names  = '{rhcc_pkg::CLS_BROWN, rhcc_pkg::CLS_BROWN, rhcc_pkg::CLS_OLIVE,
                        rhcc_pkg::CLS_OLIVE, rhcc_pkg::CLS_DARK_GREEN,
                        rhcc_pkg::CLS_TEAL, rhcc_pkg::CLS_TEAL, rhcc_pkg::CLS_NAVY,
                        rhcc_pkg::CLS_PURPLE, rhcc_pkg::CLS_MAGENTA,
                        rhcc_pkg::CLS_BROWN};
        light_names = '{rhcc_pkg::CLS_RED, rhcc_pkg::CLS_ORANGE, rhcc_pkg::CLS_YELLOW,
                        rhcc_pkg::CLS_LIME, rhcc_pkg::CLS_GREEN, rhcc_pkg::CLS_CYAN,
                        rhcc_pkg::CLS_SKY_BLUE, rhcc_pkg::CLS_BLUE,
                        rhcc_pkg::CLS_VIOLET, rhcc_pkg::CLS_PINK,
                        rhcc_pkg::CLS_RED};
        bin = 10;
        for (int i = 9; i >= 0; i--) begin
            if (hue < edges[i]) bin = i;
        end
        return dark ? dark_names[bin] : light_names[bin];
    endfunction

    function automatic rhcc_pkg::t_result classify_pixel(input rhcc_pkg::t_pixel px);
        int                r, g, b, mx, mn, spread, hue;
        rhcc_pkg::t_result res;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = (r > g) ? r : g;
        mx = (b > mx) ? b : mx;
        mn = (r < g) ? r : g;
        mn = (b < mn) ? b : mn;
        spread = mx - mn;
        res.hue_degrees = '0;
        if (mx < cfg_model[rhcc_pkg::REG_BLACK_LEVEL]) begin
            res.color_class = rhcc_pkg::CLS_BLACK;
        end else if (spread == 0 || spread < cfg_model[rhcc_pkg::REG_GRAY_SPREAD]) begin
            if (mx < cfg_model[rhcc_pkg::REG_DARK_GRAY_LIMIT])
                res.color_class = rhcc_pkg::CLS_DARK_GRAY;
            else if (mx < cfg_model[rhcc_pkg::REG_WHITE_LIMIT])
                res.color_class = rhcc_pkg::CLS_GRAY;
            else
                res.color_class = rhcc_pkg::CLS_WHITE;
        end else begin
            // SV integer division truncates toward zero, as the block does.
            if (mx == r) hue = ((g - b) * 60) / spread;
            else if (mx == g) hue = int'(rhcc_pkg::HUE_SEC_GREEN) + ((b - r) * 60) / spread;
            else hue = int'(rhcc_pkg::HUE_SEC_BLUE) + ((r - g) * 60) / spread;
            if (hue < 0) hue += int'(rhcc_pkg::HUE_FULL);
            res.hue_degrees = hue[HUE_W-1:0];
            res.color_class = hue_to_class(hue, mx < cfg_model[rhcc_pkg::REG_DARK_LIMIT]);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [CH_W-1:0] clamp_channel(input int v);
        if (v < 0) return '0;
        if (v > 255) return 8'd255;
        return v[CH_W-1:0];
    endfunction

    function automatic rhcc_pkg::t_pixel random_pixel();
        rhcc_pkg::t_pixel px;
        logic [CH_W-1:0]  ch [3];
        logic [CH_W-1:0]  tmp;
        int               base, k;
        px = rhcc_pkg::t_pixel'($urandom);
        case ($urandom_range(0, 5))
            2: begin
                base = $urandom_range(0, 255);
                px = '{base[CH_W-1:0], base[CH_W-1:0], base[CH_W-1:0]};
            end
            3: begin
                base = $urandom_range(0, 255);
                px.red   = clamp_channel(base + $urandom_range(0, 40) - 20);
                px.green = clamp_channel(base + $urandom_range(0, 40) - 20);
                px.blue  = clamp_channel(base + $urandom_range(0, 40) - 20);
            end
            4: begin
                // Strongly saturated pixel with its channels in random order.
                ch[0] = CH_W'($urandom_range(100, 255));
                ch[1] = CH_W'($urandom_range(0, 20));
                ch[2] = CH_W'($urandom_range(ch[1], ch[0]));
                k = $urandom_range(0, 2);
                tmp = ch[0]; ch[0] = ch[k]; ch[k] = tmp;
                k = $urandom_range(1, 2);
                tmp = ch[1]; ch[1] = ch[k]; ch[k] = tmp;
                px = '{ch[0], ch[1], ch[2]};
            end
            5: begin
                px.red   = CH_W'($urandom_range(0, 63));
                px.green = CH_W'($urandom_range(0, 63));
                px.blue  = CH_W'($urandom_range(0, 63));
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic add_probe(input int r, input int g, input int b, input bit known,
                             input logic [CLS_W-1:0] cls, input int hue);
        t_probe p;
        p.px = '{r[CH_W-1:0], g[CH_W-1:0], b[CH_W-1:0]};
        p.known = known;
        p.want.color_class = cls;
        p.want.hue_degrees = hue[HUE_W-1:0];
        probe_table.push_back(p);
    endtask

    // Holds the request until it is accepted, then records its expected result.
    task automatic send_pixel(input rhcc_pkg::t_pixel px, input bit known,
                              input rhcc_pkg::t_result want);
        i_pix_valid <= 1'b1;
        i_pix <= px;
        @(posedge i_clk);
        while (!o_pix_ready) @(posedge i_clk);
        pending_results.push_back(known ? want : classify_pixel(px));
        pixels_sent++;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = no_idle ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                i_pix_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_for_results();
        i_pix_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes all five registers on consecutive cycles, optionally followed by
    // writes to the unmapped indexes, which the block must ignore.
    task automatic program_regs(input logic [CH_W-1:0] vals [REG_COUNT],
                                input bit poke_unmapped);
        for (int idx = 0; idx < REG_COUNT; idx++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[CFG_IDX_W-1:0];
            i_cfg_data <= vals[idx];
            @(posedge i_clk);
            cfg_model[idx] = vals[idx];
        end
        if (poke_unmapped) begin
            for (int idx = REG_COUNT; idx < (1 << CFG_IDX_W); idx++) begin
                i_cfg_idx <= idx[CFG_IDX_W-1:0];
                i_cfg_data <= CH_W'($urandom);
                @(posedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern picks a new random mode when its counter runs out.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 128);
        end else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            0: i_res_ready <= 1'b1;
            1: i_res_ready <= ($urandom_range(0, 3) != 0);
            2: i_res_ready <= (rx_left % 6 == 0);
            default: i_res_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : res_check
        rhcc_pkg::t_result want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_results.size() == 0) begin
                $error("Result with no request outstanding: class %0d hue %0d",
                       o_res.color_class, o_res.hue_degrees);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                classes_seen[o_res.color_class] = 1'b1;
                if (o_res.color_class !== want.color_class) begin
                    $error("color_class: expected %0d, got %0d",
                           want.color_class, o_res.color_class);
                    error_count++;
                end
                if (o_res.hue_degrees !== want.hue_degrees) begin
                    $error("hue_degrees: expected %0d, got %0d",
                           want.hue_degrees, o_res.hue_degrees);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [CH_W-1:0]   vals [REG_COUNT];
        rhcc_pkg::t_result none;
        none = '0;

        cfg_model[rhcc_pkg::REG_BLACK_LEVEL]     = rhcc_pkg::RST_BLACK_LEVEL;
        cfg_model[rhcc_pkg::REG_GRAY_SPREAD]     = rhcc_pkg::RST_GRAY_SPREAD;
        cfg_model[rhcc_pkg::REG_DARK_GRAY_LIMIT] = rhcc_pkg::RST_DARK_GRAY_LIMIT;
        cfg_model[rhcc_pkg::REG_WHITE_LIMIT]     = rhcc_pkg::RST_WHITE_LIMIT;
        cfg_model[rhcc_pkg::REG_DARK_LIMIT]      = rhcc_pkg::RST_DARK_LIMIT;

        // Directed pixels, all under the reset register values.
        add_probe(0,   0,   0,   1, rhcc_pkg::CLS_BLACK,      0);
        add_probe(23,  0,   0,   1, rhcc_pkg::CLS_BLACK,      0);
        add_probe(255, 255, 255, 1, rhcc_pkg::CLS_WHITE,      0);
        add_probe(24,  24,  24,  1, rhcc_pkg::CLS_DARK_GRAY,  0);
        add_probe(128, 128, 128, 1, rhcc_pkg::CLS_GRAY,       0);
        add_probe(199, 199, 199, 1, rhcc_pkg::CLS_GRAY,       0);
        add_probe(200, 200, 200, 1, rhcc_pkg::CLS_WHITE,      0);
        add_probe(255, 0,   0,   1, rhcc_pkg::CLS_RED,        0);
        add_probe(0,   255, 0,   1, rhcc_pkg::CLS_GREEN,      120);
        add_probe(0,   0,   255, 1, rhcc_pkg::CLS_BLUE,       240);
        add_probe(255, 255, 0,   1, rhcc_pkg::CLS_LIME,       60);
        add_probe(0,   255, 255, 1, rhcc_pkg::CLS_SKY_BLUE,   180);
        add_probe(255, 0,   255, 1, rhcc_pkg::CLS_PINK,       300);
        add_probe(100, 0,   0,   1, rhcc_pkg::CLS_BROWN,      0);
        // Small negative hue parts: one truncates to zero, one wraps to 359.
        add_probe(255, 0,   1,   0, rhcc_pkg::CLS_BLACK,      0);
        add_probe(255, 0,   5,   0, rhcc_pkg::CLS_BLACK,      0);
        add_probe(50,  30,  30,  0, rhcc_pkg::CLS_BLACK,      0);
        add_probe(255, 128, 0,   0, rhcc_pkg::CLS_BLACK,      0);
        add_probe(255, 200, 0,   0, rhcc_pkg::CLS_BLACK,      0);
        add_probe(0,   255, 128, 0, rhcc_pkg::CLS_BLACK,      0);
        add_probe(0,   128, 255, 0, rhcc_pkg::CLS_BLACK,      0);
        add_probe(128, 0,   255, 0, rhcc_pkg::CLS_BLACK,      0);
        add_probe(64,  0,   64,  0, rhcc_pkg::CLS_BLACK,      0);
        add_probe(0,   80,  80,  0, rhcc_pkg::CLS_BLACK,      0);
        add_probe(60,  0,   120, 0, rhcc_pkg::CLS_BLACK,      0);

        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_table[i]) begin
            pace_sender();
            send_pixel(probe_table[i].px, probe_table[i].known, probe_table[i].want);
        end
        wait_for_results();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: vals = '{rhcc_pkg::RST_BLACK_LEVEL, rhcc_pkg::RST_GRAY_SPREAD,
                            rhcc_pkg::RST_DARK_GRAY_LIMIT, rhcc_pkg::RST_WHITE_LIMIT,
                            rhcc_pkg::RST_DARK_LIMIT};
                1: vals = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
                2: vals = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
                3: vals = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd255};
                4: vals = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0};
                default: begin
                    for (int i = 0; i < REG_COUNT; i++) vals[i] = CH_W'($urandom);
                end
            endcase
            program_regs(vals, phase == 0 || phase == 5);
            no_idle = (phase == 2);
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Let the pipeline empty completely halfway through each phase.
                if (n == ITEMS_PER_PHASE / 2) wait_for_results();
                pace_sender();
                send_pixel(random_pixel(), 1'b0, none);
            end
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixels over %0d register settings, checked %0d results",
                 pixels_sent, NUM_PHASES + 1, results_checked);
        $display("Distinct color classes observed: %0d of 21", $countones(classes_seen));
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
